// ===== hw/rtl/rv32_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_pkg: shared constants and types for the RV32IM execute block
// Operation codes, instruction classes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package rv32_pkg;

   localparam int MEM_BYTES_DEF = 4096;
   localparam int Q_DEPTH = 2;

   localparam logic [5:0] OP_ADD   = 6'd0;
   localparam logic [5:0] OP_SUB   = 6'd1;
   localparam logic [5:0] OP_SLL   = 6'd2;
   localparam logic [5:0] OP_SLT   = 6'd3;
   localparam logic [5:0] OP_SLTU  = 6'd4;
   localparam logic [5:0] OP_XOR   = 6'd5;
   localparam logic [5:0] OP_SRL   = 6'd6;
   localparam logic [5:0] OP_SRA   = 6'd7;
   localparam logic [5:0] OP_OR    = 6'd8;
   localparam logic [5:0] OP_AND   = 6'd9;
   localparam logic [5:0] OP_ADDI  = 6'd10;
   localparam logic [5:0] OP_SLTI  = 6'd11;
   localparam logic [5:0] OP_SLTIU = 6'd12;
   localparam logic [5:0] OP_XORI  = 6'd13;
   localparam logic [5:0] OP_ORI   = 6'd14;
   localparam logic [5:0] OP_ANDI  = 6'd15;
   localparam logic [5:0] OP_SLLI  = 6'd16;
   localparam logic [5:0] OP_SRLI  = 6'd17;
   localparam logic [5:0] OP_SRAI  = 6'd18;
   localparam logic [5:0] OP_LB    = 6'd19;
   localparam logic [5:0] OP_LH    = 6'd20;
   localparam logic [5:0] OP_LW    = 6'd21;
   localparam logic [5:0] OP_LBU   = 6'd22;
   localparam logic [5:0] OP_LHU   = 6'd23;
   localparam logic [5:0] OP_BEQ   = 6'd24;
   localparam logic [5:0] OP_BNE   = 6'd25;
   localparam logic [5:0] OP_BLT   = 6'd26;
   localparam logic [5:0] OP_BGE   = 6'd27;
   localparam logic [5:0] OP_BLTU  = 6'd28;
   localparam logic [5:0] OP_BGEU  = 6'd29;
   localparam logic [5:0] OP_SB    = 6'd30;
   localparam logic [5:0] OP_SH    = 6'd31;
   localparam logic [5:0] OP_SW    = 6'd32;
   localparam logic [5:0] OP_LUI   = 6'd33;
   localparam logic [5:0] OP_AUIPC = 6'd34;
   localparam logic [5:0] OP_JAL   = 6'd35;
   localparam logic [5:0] OP_JALR  = 6'd36;
   localparam logic [5:0] OP_MUL   = 6'd37;
   localparam logic [5:0] OP_MULH  = 6'd38;
   localparam logic [5:0] OP_MULHU = 6'd39;
   localparam logic [5:0] OP_DIV   = 6'd40;
   localparam logic [5:0] OP_DIVU  = 6'd41;
   localparam logic [5:0] OP_REM   = 6'd42;
   localparam logic [5:0] OP_REMU  = 6'd43;

   localparam logic [2:0] CLS_NOP   = 3'd0;
   localparam logic [2:0] CLS_ALU   = 3'd1;
   localparam logic [2:0] CLS_LOAD  = 3'd2;
   localparam logic [2:0] CLS_STORE = 3'd3;
   localparam logic [2:0] CLS_MUL   = 3'd4;
   localparam logic [2:0] CLS_DIV   = 3'd5;

   typedef struct packed {
      logic [5:0]  op;
      logic [2:0]  cls;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [31:0] imm;
   } entry_type;

endpackage

// ===== hw/rtl/rv32im_instruction_executor.sv =====
`timescale 1ns / 1ps
// Per instruction: pop from the queue, read rs1, read rs2, execute, then commit once
// the result register is free. Multiply adds a product step; divide and remainder wait
// for the one-bit-per-cycle divider; loads and stores make one data-memory access per byte.
// A MEM_BYTES that is not a power of two adds a compare-and-subtract address reduction.
// One instruction is in the back end at a time; a 2-entry queue buffers intake. Reset:
// synchronous, clears PC and register valid bits, then zeroes data memory, req_full high.
// ----------------------------------------------------------------------------
// rv32im_instruction_executor: RV32IM single-issue execute block
// Queue-style front end, sequenced back end with register file and data memory.
// ----------------------------------------------------------------------------
module rv32im_instruction_executor #(
   parameter int MEM_BYTES = rv32_pkg::MEM_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [5:0]         req_opcode,
   input  logic [4:0]         req_dest_index,
   input  logic [4:0]         req_src1_index,
   input  logic [4:0]         req_src2_index,
   input  logic signed [31:0] req_immediate,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_reg_written,
   output logic [4:0]         rsp_written_index,
   output logic signed [31:0] rsp_written_value,
   output logic [31:0]        rsp_next_pc,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data
);

   logic                q_valid;
   logic                q_pop;
   rv32_pkg::entry_type q_head;
   logic                front_full;
   logic                clearing;
   logic                out_valid;
   logic [31:0]         out_value;

   rv32_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push && !clearing),
      .full       (front_full),
      .opcode     (req_opcode),
      .dest_index (req_dest_index),
      .src1_index (req_src1_index),
      .src2_index (req_src2_index),
      .immediate  (req_immediate),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   rv32_back #(.MEM_BYTES(MEM_BYTES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .clearing          (clearing),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .out_valid         (out_valid),
      .out_pop           (rsp_pop),
      .out_reg_written   (rsp_reg_written),
      .out_written_index (rsp_written_index),
      .out_written_value (out_value),
      .out_next_pc       (rsp_next_pc)
   );

   assign req_full          = front_full || clearing;
   assign rsp_empty         = !out_valid;
   assign rsp_written_value = out_value;

endmodule

// ===== hw/rtl/rv32_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rv32_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/rv32_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_front: instruction intake and classification
// Classifies each accepted transaction and holds it in a short queue.
// ----------------------------------------------------------------------------
module rv32_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [5:0]            opcode,
   input  logic [4:0]            dest_index,
   input  logic [4:0]            src1_index,
   input  logic [4:0]            src2_index,
   input  logic [31:0]           immediate,
   output logic                  q_valid,
   output rv32_pkg::entry_type   q_head,
   input  logic                  q_pop
);

   rv32_pkg::entry_type q_ff [rv32_pkg::Q_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic [2:0] cls;
   logic       do_push, do_pop;

   always_comb begin
      if (opcode inside {[rv32_pkg::OP_ADD:rv32_pkg::OP_SRAI],
                         [rv32_pkg::OP_BEQ:rv32_pkg::OP_BGEU],
                         [rv32_pkg::OP_LUI:rv32_pkg::OP_JALR]}) begin
         cls = rv32_pkg::CLS_ALU;
      end else if (opcode inside {[rv32_pkg::OP_LB:rv32_pkg::OP_LHU]}) begin
         cls = rv32_pkg::CLS_LOAD;
      end else if (opcode inside {[rv32_pkg::OP_SB:rv32_pkg::OP_SW]}) begin
         cls = rv32_pkg::CLS_STORE;
      end else if (opcode inside {[rv32_pkg::OP_MUL:rv32_pkg::OP_MULHU]}) begin
         cls = rv32_pkg::CLS_MUL;
      end else if (opcode inside {[rv32_pkg::OP_DIV:rv32_pkg::OP_REMU]}) begin
         cls = rv32_pkg::CLS_DIV;
      end else begin
         cls = rv32_pkg::CLS_NOP;
      end
   end

   assign full    = (count_ff == 2'(rv32_pkg::Q_DEPTH));
   assign q_valid = (count_ff != 2'd0);
   assign q_head  = q_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= '{op: opcode, cls: cls, rd: dest_index, rs1: src1_index,
                              rs2: src2_index, imm: immediate};
      end
   end

endmodule

// ===== hw/rtl/rv32_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, 32 steps.
// ----------------------------------------------------------------------------
module rv32_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted, diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      diff    = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = 32'd0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/rv32_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_back: execution sequencer
// Reads operands, runs ALU, multiply, divide and byte-wise memory steps,
// commits the register write and program counter, holds the result.
// ----------------------------------------------------------------------------
module rv32_back #(
   parameter int MEM_BYTES = rv32_pkg::MEM_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  rv32_pkg::entry_type q_head,
   output logic                q_pop,
   output logic                clearing,
   input  logic                csr_write_enable,
   input  logic [31:0]         csr_write_data,
   output logic                out_valid,
   input  logic                out_pop,
   output logic                out_reg_written,
   output logic [4:0]          out_written_index,
   output logic [31:0]         out_written_value,
   output logic [31:0]         out_next_pc
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam bit MEM_POW2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);
   // largest multiple of the memory size tried first by the address reduction
   localparam logic [32:0] MSUB_TOP = 33'(MEM_BYTES) << (32 - AW);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_RS1   = 4'd2;
   localparam logic [3:0] ST_RS2   = 4'd3;
   localparam logic [3:0] ST_EXEC  = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_ADDR  = 4'd7;
   localparam logic [3:0] ST_LWAIT = 4'd8;
   localparam logic [3:0] ST_LOAD  = 4'd9;
   localparam logic [3:0] ST_STORE = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [5:0]  op_ff, op_in;
   logic [2:0]  cls_ff, cls_in;
   logic [4:0]  rd_ff, rd_in;
   logic [4:0]  rs2_ff, rs2_in;
   logic [31:0] imm_ff, imm_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] v_ff, v_in;
   logic        wr_ff, wr_in;
   logic [31:0] npc_ff, npc_in;
   logic [31:0] pc_ff, pc_in;
   logic [1:0]  k_ff, k_in;
   logic [AW-1:0] maddr_ff, maddr_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] rf_valid_ff, rf_valid_in;
   logic [31:0] red_ff, red_in;
   logic [32:0] msub_ff, msub_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_wr_ff, out_wr_in;
   logic [4:0]  out_idx_ff, out_idx_in;
   logic [31:0] out_val_ff, out_val_in;
   logic [31:0] out_npc_ff, out_npc_in;

   logic [4:0]  rf_raddr;
   logic [31:0] rf_rdata;
   logic        rf_we;
   logic [31:0] rf_opnd;
   logic        mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]  mem_wdata;
   logic [7:0]  mem_rdata;

   logic        div_start;
   logic [31:0] div_dividend, div_divisor;
   logic        div_done;
   logic [31:0] div_quo, div_rem;

   logic [4:0]  shamt;
   logic        is_signed_div;
   logic [1:0]  k_last;
   logic [AW-1:0] maddr_next;
   logic [31:0] asm_word;
   logic [32:0] mul_a, mul_b;
   logic [65:0] mul_full;
   logic [31:0] red_next;
   logic        take;
   logic        commit;

   rv32_ram #(.WIDTH(32), .DEPTH(32)) u_regs (
      .clock (clock),
      .we    (rf_we),
      .waddr (rd_ff),
      .wdata (v_ff),
      .raddr (rf_raddr),
      .rdata (rf_rdata)
   );

   rv32_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (maddr_ff),
      .rdata (mem_rdata)
   );

   rv32_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Operand from the register file; unwritten entries and x0 read as zero
   always_comb begin
      rf_raddr = (state_ff == ST_IDLE) ? q_head.rs1 : rs2_ff;
      rf_opnd  = rf_rdata;
   end

   assign shamt = (op_ff inside {rv32_pkg::OP_SLLI, rv32_pkg::OP_SRLI, rv32_pkg::OP_SRAI})
                  ? imm_ff[4:0] : b_ff[4:0];
   assign is_signed_div = (op_ff == rv32_pkg::OP_DIV) || (op_ff == rv32_pkg::OP_REM);
   assign k_last = (op_ff inside {rv32_pkg::OP_LB, rv32_pkg::OP_LBU, rv32_pkg::OP_SB}) ? 2'd0 :
                   (op_ff inside {rv32_pkg::OP_LH, rv32_pkg::OP_LHU, rv32_pkg::OP_SH}) ? 2'd1 :
                   2'd3;
   assign maddr_next = (maddr_ff == AW'(MEM_BYTES - 1)) ? '0 : maddr_ff + AW'(1);
   assign asm_word = v_ff | ({24'd0, mem_rdata} << {k_ff, 3'b000});
   assign mul_a = {(op_ff == rv32_pkg::OP_MULH) & a_ff[31], a_ff};
   assign mul_b = {(op_ff == rv32_pkg::OP_MULH) & b_ff[31], b_ff};
   assign mul_full = $signed(mul_a) * $signed(mul_b);
   assign red_next = ({1'b0, red_ff} >= msub_ff) ? 32'({1'b0, red_ff} - msub_ff) : red_ff;
   assign commit = (state_ff == ST_DONE) && (!out_valid_ff || out_pop);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cls_in       = cls_ff;
      rd_in        = rd_ff;
      rs2_in       = rs2_ff;
      imm_in       = imm_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      v_in         = v_ff;
      wr_in        = wr_ff;
      npc_in       = npc_ff;
      pc_in        = pc_ff;
      k_in         = k_ff;
      maddr_in     = maddr_ff;
      clr_in       = clr_ff;
      prod_in      = prod_ff;
      rf_valid_in  = rf_valid_ff;
      red_in       = red_ff;
      msub_in      = msub_ff;
      out_valid_in = out_valid_ff;
      out_wr_in    = out_wr_ff;
      out_idx_in   = out_idx_ff;
      out_val_in   = out_val_ff;
      out_npc_in   = out_npc_ff;
      q_pop        = 1'b0;
      rf_we        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = maddr_ff;
      mem_wdata    = b_ff[8*k_ff +: 8];
      div_start    = 1'b0;
      div_dividend = a_ff;
      div_divisor  = b_ff;
      take         = 1'b0;

      if (out_valid_ff && out_pop) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'd0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               op_in    = q_head.op;
               cls_in   = q_head.cls;
               rd_in    = q_head.rd;
               rs2_in   = q_head.rs2;
               imm_in   = q_head.imm;
               // a_ff temporarily carries the rs1 number until the data arrives
               a_in     = {27'd0, q_head.rs1};
               state_in = ST_RS1;
            end
         end
         ST_RS1: begin
            a_in     = (a_ff[4:0] != 5'd0 && rf_valid_ff[a_ff[4:0]]) ? rf_opnd : 32'd0;
            state_in = ST_RS2;
         end
         ST_RS2: begin
            b_in     = (rs2_ff != 5'd0 && rf_valid_ff[rs2_ff]) ? rf_opnd : 32'd0;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            npc_in   = pc_ff + 32'd4;
            wr_in    = 1'b0;
            v_in     = 32'd0;
            state_in = ST_DONE;
            case (cls_ff)
               rv32_pkg::CLS_ALU: begin
                  wr_in = 1'b1;
                  case (op_ff)
                     rv32_pkg::OP_ADD:   v_in = a_ff + b_ff;
                     rv32_pkg::OP_SUB:   v_in = a_ff - b_ff;
                     rv32_pkg::OP_SLL,
                     rv32_pkg::OP_SLLI:  v_in = a_ff << shamt;
                     rv32_pkg::OP_SLT:   v_in = {31'd0, $signed(a_ff) < $signed(b_ff)};
                     rv32_pkg::OP_SLTU:  v_in = {31'd0, a_ff < b_ff};
                     rv32_pkg::OP_XOR:   v_in = a_ff ^ b_ff;
                     rv32_pkg::OP_SRL,
                     rv32_pkg::OP_SRLI:  v_in = a_ff >> shamt;
                     rv32_pkg::OP_SRA,
                     rv32_pkg::OP_SRAI:  v_in = 32'($signed(a_ff) >>> shamt);
                     rv32_pkg::OP_OR:    v_in = a_ff | b_ff;
                     rv32_pkg::OP_AND:   v_in = a_ff & b_ff;
                     rv32_pkg::OP_ADDI:  v_in = a_ff + imm_ff;
                     rv32_pkg::OP_SLTI:  v_in = {31'd0, $signed(a_ff) < $signed(imm_ff)};
                     rv32_pkg::OP_SLTIU: v_in = {31'd0, a_ff < imm_ff};
                     rv32_pkg::OP_XORI:  v_in = a_ff ^ imm_ff;
                     rv32_pkg::OP_ORI:   v_in = a_ff | imm_ff;
                     rv32_pkg::OP_ANDI:  v_in = a_ff & imm_ff;
                     rv32_pkg::OP_LUI:   v_in = imm_ff;
                     rv32_pkg::OP_AUIPC: v_in = pc_ff + imm_ff;
                     rv32_pkg::OP_JAL: begin
                        v_in   = pc_ff + 32'd4;
                        npc_in = pc_ff + imm_ff;
                     end
                     rv32_pkg::OP_JALR: begin
                        v_in   = pc_ff + 32'd4;
                        npc_in = (a_ff + imm_ff) & 32'hFFFF_FFFE;
                     end
                     default: begin
                        // branches
                        wr_in = 1'b0;
                        case (op_ff)
                           rv32_pkg::OP_BEQ:  take = (a_ff == b_ff);
                           rv32_pkg::OP_BNE:  take = (a_ff != b_ff);
                           rv32_pkg::OP_BLT:  take = $signed(a_ff) < $signed(b_ff);
                           rv32_pkg::OP_BGE:  take = !($signed(a_ff) < $signed(b_ff));
                           rv32_pkg::OP_BLTU: take = (a_ff < b_ff);
                           rv32_pkg::OP_BGEU: take = (a_ff >= b_ff);
                           default:           take = 1'b0;
                        endcase
                        if (take) begin
                           npc_in = pc_ff + imm_ff;
                        end
                     end
                  endcase
               end
               rv32_pkg::CLS_MUL: begin
                  prod_in  = mul_full[63:0];
                  state_in = ST_MUL;
               end
               rv32_pkg::CLS_DIV: begin
                  div_start    = 1'b1;
                  div_dividend = (is_signed_div && a_ff[31]) ? (32'd0 - a_ff) : a_ff;
                  div_divisor  = (is_signed_div && b_ff[31]) ? (32'd0 - b_ff) : b_ff;
                  state_in     = ST_DIV;
               end
               rv32_pkg::CLS_LOAD,
               rv32_pkg::CLS_STORE: begin
                  // reduce the effective address (base plus immediate) modulo the memory size
                  red_in   = a_ff + imm_ff;
                  msub_in  = MSUB_TOP;
                  state_in = ST_ADDR;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_MUL: begin
            wr_in    = 1'b1;
            v_in     = (op_ff == rv32_pkg::OP_MUL) ? prod_ff[31:0] : prod_ff[63:32];
            state_in = ST_DONE;
         end
         ST_DIV: begin
            if (div_done) begin
               wr_in    = 1'b1;
               state_in = ST_DONE;
               if (op_ff == rv32_pkg::OP_DIV || op_ff == rv32_pkg::OP_DIVU) begin
                  if (b_ff == 32'd0) begin
                     v_in = 32'hFFFF_FFFF;
                  end else if (is_signed_div && (a_ff[31] != b_ff[31])) begin
                     v_in = 32'd0 - div_quo;
                  end else begin
                     v_in = div_quo;
                  end
               end else begin
                  v_in = (is_signed_div && a_ff[31]) ? (32'd0 - div_rem) : div_rem;
               end
            end
         end
         ST_ADDR: begin
            if (MEM_POW2) begin
               maddr_in = red_ff[AW-1:0];
               k_in     = 2'd0;
               state_in = (cls_ff == rv32_pkg::CLS_LOAD) ? ST_LWAIT : ST_STORE;
            end else begin
               // one compare and subtract per cycle, largest multiple first
               red_in  = red_next;
               msub_in = msub_ff >> 1;
               if (msub_ff == 33'(MEM_BYTES)) begin
                  maddr_in = red_next[AW-1:0];
                  k_in     = 2'd0;
                  state_in = (cls_ff == rv32_pkg::CLS_LOAD) ? ST_LWAIT : ST_STORE;
               end
            end
         end
         ST_LWAIT: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            v_in     = asm_word;
            maddr_in = maddr_next;
            k_in     = k_ff + 2'd1;
            state_in = ST_LWAIT;
            if (k_ff == k_last) begin
               wr_in    = 1'b1;
               state_in = ST_DONE;
               case (op_ff)
                  rv32_pkg::OP_LB:  v_in = {{24{asm_word[7]}}, asm_word[7:0]};
                  rv32_pkg::OP_LH:  v_in = {{16{asm_word[15]}}, asm_word[15:0]};
                  rv32_pkg::OP_LBU: v_in = {24'd0, asm_word[7:0]};
                  rv32_pkg::OP_LHU: v_in = {16'd0, asm_word[15:0]};
                  default:          v_in = asm_word;
               endcase
            end
         end
         ST_STORE: begin
            mem_we   = 1'b1;
            maddr_in = maddr_next;
            k_in     = k_ff + 2'd1;
            if (k_ff == k_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               out_valid_in = 1'b1;
               out_wr_in    = wr_ff && (rd_ff != 5'd0);
               out_idx_in   = (wr_ff && rd_ff != 5'd0) ? rd_ff : 5'd0;
               out_val_in   = (wr_ff && rd_ff != 5'd0) ? v_ff : 32'd0;
               out_npc_in   = npc_ff;
               pc_in        = npc_ff;
               if (wr_ff && rd_ff != 5'd0) begin
                  rf_we              = 1'b1;
                  rf_valid_in[rd_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         pc_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= 32'd0;
         rf_valid_ff  <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         rf_valid_ff  <= rf_valid_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff      <= op_in;
      cls_ff     <= cls_in;
      rd_ff      <= rd_in;
      rs2_ff     <= rs2_in;
      imm_ff     <= imm_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      v_ff       <= v_in;
      wr_ff      <= wr_in;
      npc_ff     <= npc_in;
      k_ff       <= k_in;
      maddr_ff   <= maddr_in;
      prod_ff    <= prod_in;
      red_ff     <= red_in;
      msub_ff    <= msub_in;
      out_wr_ff  <= out_wr_in;
      out_idx_ff <= out_idx_in;
      out_val_ff <= out_val_in;
      out_npc_ff <= out_npc_in;
   end

   assign clearing          = (state_ff == ST_CLEAR);
   assign out_valid         = out_valid_ff;
   assign out_reg_written   = out_wr_ff;
   assign out_written_index = out_idx_ff;
   assign out_written_value = out_val_ff;
   assign out_next_pc       = out_npc_ff;

endmodule
